FILE: rtl/core/slir_pkg.sv
// Shared types and constants for the sorted list insert/remove block.
package slir_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    // Contents of one slot, as handed between neighboring cells.
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
    } slot_t;

endpackage

FILE: rtl/core/slir_cell.sv
// One slot of the sorted row: compares against the command value and shifts.
module slir_cell
    import slir_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  logic  left_lt,
    input  slot_t left_slot,
    input  slot_t right_slot,
    output logic  lt,
    output logic  eq,
    output slot_t slot
);

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    // Stored values are ascending, so lt is a run of ones followed by zeros.
    assign lt = valid_reg && (value_reg < cmd.value);
    assign eq = valid_reg && (value_reg == cmd.value);

    assign slot.valid = valid_reg;
    assign slot.value = value_reg;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (cmd.ins && !lt)
        begin
            // The first cell that is not smaller takes the new value; the
            // ones after it take their left neighbor's contents.
            if (left_lt)
            begin
                valid_next = 1'b1;
                value_next = cmd.value;
            end
            else
            begin
                valid_next = left_slot.valid;
                value_next = left_slot.value;
            end
        end
        else if (cmd.rem && !lt)
        begin
            // The removed copy sits at the first cell that is not smaller.
            valid_next = right_slot.valid;
            value_next = right_slot.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: rtl/core/sorted_list_insert_remove.sv
// Top level: a row of compare-and-shift cells that keeps values in ascending order.
// Each item (insert or remove) is accepted on start, and its result appears with done
// high in the cycle after acceptance; busy is always low, so one item can be
// started every cycle. The row of cells updates all slots at once, and the slowest path
// is the compare in each cell followed by the match reduction across the row. The
// receiver cannot stall: each result is shown for one cycle only and must be captured
// then. Entry count and all slot valid bits are cleared by reset, with no clearing pass.
module sorted_list_insert_remove
    import slir_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     opcode,
    input  logic signed [DATA_W-1:0] item_value,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] removed_value,
    output logic [4:0]               entry_count
);

    logic                     accept;
    logic                     is_insert;
    logic                     full;
    logic                     empty;
    logic                     found;
    cmd_t                     cmd;
    logic [CAPACITY-1:0]      lt_vec;
    logic [CAPACITY-1:0]      eq_vec;
    slot_t                    slots [CAPACITY];

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     done_reg;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [DATA_W-1:0] removed_reg;
    logic signed [DATA_W-1:0] removed_next;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign is_insert = (opcode_t'(opcode) == OP_INSERT);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign found     = |eq_vec;

    assign cmd.value = item_value;
    assign cmd.ins   = accept && is_insert && !full;
    assign cmd.rem   = accept && !is_insert && found;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            slot_t left_slot;
            slot_t right_slot;
            logic  left_lt;

            if (g == 0)
            begin : g_first
                // Everything in front of the first cell counts as smaller.
                assign left_lt   = 1'b1;
                assign left_slot = slots[g];
            end
            else
            begin : g_mid
                assign left_lt   = lt_vec[g-1];
                assign left_slot = slots[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_slot = '0;
            end
            else
            begin : g_inner
                assign right_slot = slots[g+1];
            end

            slir_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .left_lt    (left_lt),
                .left_slot  (left_slot),
                .right_slot (right_slot),
                .lt         (lt_vec[g]),
                .eq         (eq_vec[g]),
                .slot       (slots[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next   = count_reg;
        status_next  = ST_OK;
        removed_next = '0;
        if (is_insert)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            priority if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else if (!found)
            begin
                status_next = ST_NOT_FOUND;
            end
            else
            begin
                removed_next = item_value;
                count_next   = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entry_count   = 5'(count_reg);

endmodule

FILE: rtl/core/slir_checker.sv
// Port-level checks for the sorted list block and their bind to the top level.
module slir_checker
    import slir_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     done,
    input logic [1:0]               status,
    input logic signed [DATA_W-1:0] removed_value,
    input logic [4:0]               entry_count
);

    // Every accepted item gives exactly one result in the following cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted item gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without an accepted item");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_t'(status) == ST_FULL) |-> (entry_count == 5'(CAPACITY)))
        else $error("full reported with a count below capacity");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_t'(status) == ST_EMPTY) |-> (entry_count == 5'd0))
        else $error("empty reported with a nonzero count");

    a_failed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_t'(status) != ST_OK) |-> (removed_value == '0))
        else $error("refused item returned a value");

endmodule

bind sorted_list_insert_remove slir_checker u_slir_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .removed_value (removed_value),
    .entry_count   (entry_count)
);
